// ===== design/kmd_pkg.sv =====
// Shared types, constants and the key-to-LED table of the key matrix debouncer.
package kmd_pkg;

	localparam int NUM_KEYS_DEF   = 10;
	localparam int RAW_W          = 10;
	localparam int TIME_W         = 32;
	localparam int DEB_W          = 16;
	localparam int KEY_W          = 4;
	localparam int LED_W          = 5;
	localparam int LED_KEY_W      = 5;
	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd20;

	typedef struct packed {
		logic [RAW_W-1:0]  raw_pressed;
		logic [TIME_W-1:0] now_ms;
	} scan_word_t;

	typedef struct packed {
		logic [KEY_W-1:0] key_index;
		logic             pressed;
		logic [LED_W-1:0] led_pixel;
		logic             last;
	} evt_word_t;

	function automatic logic [LED_W-1:0] led_of_key(input logic [LED_KEY_W-1:0] k);
		logic [LED_W-1:0] px;
		unique case (k)
			5'd0:    px = 5'd3;
			5'd1:    px = 5'd2;
			5'd2:    px = 5'd11;
			5'd3:    px = 5'd14;
			5'd4:    px = 5'd15;
			5'd5:    px = 5'd0;
			5'd6:    px = 5'd4;
			5'd7:    px = 5'd1;
			5'd8:    px = 5'd12;
			5'd9:    px = 5'd13;
			default: px = 5'd0;
		endcase
		return px;
	endfunction

endpackage

// ===== design/kmd_lane.sv =====
// One key lane: raw reading, debounced state, change time and the event decision.
module kmd_lane import kmd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic              level,
	input  logic [TIME_W-1:0] now_ms,
	input  logic [DEB_W-1:0]  hold_ms,
	output logic              fire,
	output logic              fire_level
);

	logic              raw_seen_q;
	logic              debounced_q;
	logic [TIME_W-1:0] change_time_q;
	logic [TIME_W-1:0] elapsed;

	assign elapsed    = now_ms - change_time_q;
	assign fire       = (level == raw_seen_q) && (elapsed >= TIME_W'(hold_ms))
		&& (debounced_q != raw_seen_q);
	assign fire_level = raw_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_seen_q    <= 1'b0;
			debounced_q   <= 1'b0;
			change_time_q <= '0;
		end else if (take) begin
			if (level != raw_seen_q) begin
				raw_seen_q    <= level;
				change_time_q <= now_ms;
			end else if (fire) begin
				debounced_q <= raw_seen_q;
			end
		end
	end

endmodule

// ===== design/kmd_merge.sv =====
// Merge stage: emits the lanes' events of one scan in key order, one word per cycle while evt_stall allows it.
module kmd_merge import kmd_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pend_valid,
	input  logic [NUM_KEYS-1:0] pend_mask,
	input  logic [NUM_KEYS-1:0] pend_lvl,
	output logic                pend_ready,
	output logic                evt_valid,
	input  logic                evt_stall,
	output evt_word_t           evt
);

	localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	logic [NUM_KEYS-1:0] mask_q;
	logic [NUM_KEYS-1:0] lvl_q;
	logic                out_valid_q;
	evt_word_t           out_q;
	logic [NUM_KEYS-1:0] low;
	logic [NUM_KEYS-1:0] rest;
	logic [IDX_W-1:0]    idx;
	logic                emit;

	assign low  = mask_q & (~mask_q + NUM_KEYS'(1));
	assign rest = mask_q & ~low;
	assign emit = (mask_q != '0) && (!out_valid_q || !evt_stall);
	assign pend_ready = (mask_q == '0) || (emit && (rest == '0));

	always_comb begin
		idx = '0;
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (low[i]) begin
				idx = idx | IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pend_ready) begin
				mask_q <= pend_valid ? pend_mask : '0;
			end else if (emit) begin
				mask_q <= rest;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!evt_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_ready && pend_valid) begin
			lvl_q <= pend_lvl;
		end
		if (emit) begin
			out_q.key_index <= KEY_W'(idx);
			out_q.pressed   <= lvl_q[idx];
			out_q.led_pixel <= led_of_key(LED_KEY_W'(idx));
			out_q.last      <= (rest == '0);
		end
	end

	assign evt_valid = out_valid_q;
	assign evt       = out_q;

endmodule

// ===== design/key_matrix_debounce_events_top.sv =====
// Top level of the key matrix debouncer with press and release events.
// Usage:
//   scan channel (scan_valid / scan_stall / scan): one word per matrix scan,
//   the raw key levels and the millisecond time of the scan.
//   evt channel (evt_valid / evt_stall / evt): one word per debounced change,
//   in ascending key order, with the key's LED pixel; last marks the final
//   word of a scan. A scan with no change gives no word.
//   debounce channel (debounce_valid / debounce_ready / hold_ms): writes the
//   debounce time; always ready. Write it only while no words are in flight.
// A scan's first word passes the s1 registers, the merge mask and the output word.
// Throughput: every key lane judges the whole scan at once, so a scan is taken
// each cycle while scan_stall is low; the merge stage then sends one word per
// cycle while evt_stall allows it, at most NUM_KEYS words for one scan.
// One decided scan waits between the lanes and the merge stage; scan_stall rises
// while it cannot move on. evt_stall holds the output word and backs up the
// merge stage and then the scan channel.
// Reset: all keys read released, change times zero, debounce time 20 ms.
module key_matrix_debounce_events_top import kmd_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             scan_valid,
	output logic             scan_stall,
	input  scan_word_t       scan,
	output logic             evt_valid,
	input  logic             evt_stall,
	output evt_word_t        evt,
	input  logic             debounce_valid,
	output logic             debounce_ready,
	input  logic [DEB_W-1:0] hold_ms
);

	logic [DEB_W-1:0]    debounce_q;
	logic [NUM_KEYS-1:0] fire;
	logic [NUM_KEYS-1:0] fire_lvl;
	logic                scan_take;
	logic                valid_s1;
	logic [NUM_KEYS-1:0] mask_s1;
	logic [NUM_KEYS-1:0] lvl_s1;
	logic                merge_ready;

	assign debounce_ready = 1'b1;
	assign scan_stall     = valid_s1 && !merge_ready;
	assign scan_take      = scan_valid && !scan_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (debounce_valid && debounce_ready) begin
			debounce_q <= hold_ms;
		end
	end

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		logic level;
		if (k < RAW_W) begin : g_raw
			assign level = scan.raw_pressed[k];
		end else begin : g_none
			assign level = 1'b0;
		end
		kmd_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.take       (scan_take),
			.level      (level),
			.now_ms     (scan.now_ms),
			.hold_ms    (debounce_q),
			.fire       (fire[k]),
			.fire_level (fire_lvl[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan_take) begin
			valid_s1 <= |fire;
		end else if (merge_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_take) begin
			mask_s1 <= fire;
			lvl_s1  <= fire_lvl;
		end
	end

	kmd_merge #(.NUM_KEYS(NUM_KEYS)) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.pend_valid(valid_s1),
		.pend_mask (mask_s1),
		.pend_lvl  (lvl_s1),
		.pend_ready(merge_ready),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt)
	);

endmodule

// ===== design/kmd_checker.sv =====
// Port checker for the key matrix debouncer and its bind to the top level.
module kmd_checker import kmd_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	input logic      evt_valid,
	input logic      evt_stall,
	input evt_word_t evt
);

	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_stall |=> evt_valid)
		else $error("event word dropped while stalled");

	a_evt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_stall |=> $stable(evt))
		else $error("stalled event word changed");

	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid |-> (NUM_KEYS > 16) || (int'(evt.key_index) < NUM_KEYS))
		else $error("key index beyond key count");

	a_key_order: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_stall && !evt.last |=>
			evt_valid && ((NUM_KEYS > 16) || (evt.key_index > $past(evt.key_index))))
		else $error("events of one scan out of key order or broken off");

endmodule

bind key_matrix_debounce_events_top kmd_checker #(.NUM_KEYS(NUM_KEYS)) u_kmd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.evt_valid(evt_valid),
	.evt_stall(evt_stall),
	.evt      (evt)
);

// ===== bench/kmd_event_checker.sv =====
// Checker for the key matrix debouncer: predicts event words from accepted scans and compares.
`timescale 1ns / 1ps
module kmd_event_checker import kmd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             scan_valid,
	input  logic             scan_stall,
	input  scan_word_t       scan,
	input  logic             evt_valid,
	input  logic             evt_stall,
	input  evt_word_t        evt,
	input  logic             debounce_valid,
	input  logic             debounce_ready,
	input  logic [DEB_W-1:0] hold_ms,
	output int               fail_count,
	output int               events_checked,
	output int               pending
);
	localparam int KEYS = NUM_KEYS_DEF;
	localparam logic [KEYS*LED_W-1:0] KEY_PIXELS = {
		5'd13, 5'd12, 5'd1, 5'd4, 5'd0, 5'd15, 5'd14, 5'd11, 5'd2, 5'd3
	};

	logic [KEYS-1:0]   raw_seen;
	logic [KEYS-1:0]   debounced;
	logic [TIME_W-1:0] change_time [KEYS];
	logic [DEB_W-1:0]  deb_time;
	evt_word_t         due_events [$];

	initial begin
		fail_count     = 0;
		events_checked = 0;
		pending        = 0;
	end

	task automatic debounce_scan(input scan_word_t s);
		logic [TIME_W-1:0] elapsed;
		evt_word_t         ev;
		int                found;
		found = 0;
		for (int k = 0; k < KEYS; k++) begin
			elapsed = s.now_ms - change_time[k];
			if (s.raw_pressed[k] != raw_seen[k]) begin
				raw_seen[k]    = s.raw_pressed[k];
				change_time[k] = s.now_ms;
			end else if (elapsed >= TIME_W'(deb_time) && debounced[k] != raw_seen[k]) begin
				debounced[k] = raw_seen[k];
				ev.key_index = KEY_W'(k);
				ev.pressed   = raw_seen[k];
				ev.led_pixel = KEY_PIXELS[k*LED_W +: LED_W];
				ev.last      = 1'b0;
				due_events.push_back(ev);
				found++;
			end
		end
		// flag the final word of the scan
		if (found > 0) begin
			ev      = due_events.pop_back();
			ev.last = 1'b1;
			due_events.push_back(ev);
		end
	endtask

	task automatic check_event(input evt_word_t got);
		evt_word_t want;
		if (due_events.size() == 0) begin
			$error("event word with none due: key_index %0d pressed %0d",
				got.key_index, got.pressed);
			fail_count++;
		end else begin
			want = due_events.pop_front();
			events_checked++;
			if (got.key_index !== want.key_index) begin
				$error("key_index: expected %0d, got %0d", want.key_index, got.key_index);
				fail_count++;
			end
			if (got.pressed !== want.pressed) begin
				$error("pressed: expected %0d, got %0d", want.pressed, got.pressed);
				fail_count++;
			end
			if (got.led_pixel !== want.led_pixel) begin
				$error("led_pixel: expected %0d, got %0d", want.led_pixel, got.led_pixel);
				fail_count++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_seen  = '0;
			debounced = '0;
			for (int k = 0; k < KEYS; k++) begin
				change_time[k] = '0;
			end
			deb_time = DEBOUNCE_RESET;
			due_events.delete();
		end else begin
			if (evt_valid && !evt_stall) begin
				check_event(evt);
			end
			if (scan_valid && !scan_stall) begin
				debounce_scan(scan);
			end
			if (debounce_valid && debounce_ready) begin
				deb_time = hold_ms;
			end
		end
		pending = due_events.size();
	end

endmodule

// ===== bench/tb_key_matrix_debounce_events_top.sv =====
// Testbench top for the key matrix debouncer: clock, reset, scan stimulus, output stalls, verdict.
`timescale 1ns / 1ps
module tb_key_matrix_debounce_events_top;
	import kmd_pkg::*;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             scan_valid;
	logic             scan_stall;
	scan_word_t       scan;
	logic             evt_valid;
	logic             evt_stall;
	evt_word_t        evt;
	logic             debounce_valid;
	logic             debounce_ready;
	logic [DEB_W-1:0] hold_ms;

	int fail_count;
	int events_checked;
	int pending;

	logic [RAW_W-1:0]  cur_raw;
	logic [TIME_W-1:0] cur_time;
	logic [DEB_W-1:0]  cur_deb;
	int                scans_sent;
	bit                tx_quiet;
	bit                rx_quiet;
	bit                long_hold_req;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	key_matrix_debounce_events_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.scan_valid     (scan_valid),
		.scan_stall     (scan_stall),
		.scan           (scan),
		.evt_valid      (evt_valid),
		.evt_stall      (evt_stall),
		.evt            (evt),
		.debounce_valid (debounce_valid),
		.debounce_ready (debounce_ready),
		.hold_ms        (hold_ms)
	);

	kmd_event_checker watch (
		.clk            (clk),
		.arst_n         (arst_n),
		.scan_valid     (scan_valid),
		.scan_stall     (scan_stall),
		.scan           (scan),
		.evt_valid      (evt_valid),
		.evt_stall      (evt_stall),
		.evt            (evt),
		.debounce_valid (debounce_valid),
		.debounce_ready (debounce_ready),
		.hold_ms        (hold_ms),
		.fail_count     (fail_count),
		.events_checked (events_checked),
		.pending        (pending)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else begin
			return $urandom_range(8, 40);
		end
	endfunction

	task automatic send_scan(input logic [RAW_W-1:0] raw, input logic [TIME_W-1:0] t);
		int         gap;
		scan_word_t w;
		gap = tx_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			scan_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w.raw_pressed = raw;
		w.now_ms      = t;
		scan_valid <= 1'b1;
		scan       <= w;
		do @(posedge clk); while (scan_stall);
		scans_sent++;
	endtask

	task automatic drain_events(input int settle);
		int waited;
		waited = 0;
		scan_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_debounce(input logic [DEB_W-1:0] v);
		drain_events(8);
		debounce_valid <= 1'b1;
		hold_ms        <= v;
		do @(posedge clk); while (!debounce_ready);
		debounce_valid <= 1'b0;
		cur_deb = v;
	endtask

	task automatic random_scan();
		logic [RAW_W-1:0] flips;
		int               r;
		int               step_max;
		r        = $urandom_range(0, 99);
		step_max = int'(cur_deb) + int'(cur_deb) / 2 + 3;
		if (r < 8) begin
			cur_raw  = RAW_W'($urandom);
			cur_time = $urandom;
		end else begin
			flips = '0;
			for (int k = 0; k < RAW_W; k++) begin
				if ($urandom_range(0, 99) < 12) begin
					flips[k] = 1'b1;
				end
			end
			cur_raw = cur_raw ^ flips;
			if (r < 12) begin
				cur_time = cur_time - $urandom_range(1, 50);
			end else if (r < 22) begin
				cur_time = cur_time + TIME_W'(cur_deb);
			end else begin
				cur_time = cur_time + $urandom_range(0, step_max);
			end
		end
		send_scan(cur_raw, cur_time);
	endtask

	task automatic run_phase(input int n);
		for (int i = 0; i < n; i++) begin
			if (i == n / 2) begin
				drain_events(0);
			end
			random_scan();
		end
	endtask

	initial begin
		int hold_left;
		int stall_left;
		int free_left;
		hold_left  = 0;
		stall_left = 0;
		free_left  = 0;
		evt_stall  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left     = 300;
			end
			if (hold_left > 0) begin
				evt_stall <= 1'b1;
				hold_left--;
			end else if (rx_quiet) begin
				evt_stall <= 1'b0;
			end else if (stall_left > 0) begin
				evt_stall <= 1'b1;
				stall_left--;
			end else if (free_left > 0) begin
				evt_stall <= 1'b0;
				free_left--;
			end else begin
				evt_stall <= 1'b0;
				free_left  = $urandom_range(0, 12);
				stall_left = pick_gap();
			end
		end
	end

	initial begin
		int deb_rand;
		arst_n         = 1'b0;
		scan_valid     = 1'b0;
		scan           = '0;
		debounce_valid = 1'b0;
		hold_ms        = '0;
		tx_quiet       = 1'b0;
		rx_quiet       = 1'b0;
		long_hold_req  = 1'b0;
		scans_sent     = 0;
		cur_deb        = DEBOUNCE_RESET;
		cur_raw        = '0;
		cur_time       = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_scan(10'h000, 32'd0);
		send_scan(10'h3FF, 32'd5);
		send_scan(10'h3FF, 32'd10);
		send_scan(10'h3FF, 32'd25);
		send_scan(10'h000, 32'd30);
		send_scan(10'h000, 32'd49);
		send_scan(10'h000, 32'd50);
		// wrap the timestamp through zero
		send_scan(10'h001, 32'hFFFF_FFF0);
		send_scan(10'h001, 32'h0000_0004);
		// step time backwards
		send_scan(10'h200, 32'h0000_0010);
		send_scan(10'h200, 32'h0000_0008);
		send_scan(10'h155, 32'd100);
		send_scan(10'h155, 32'd119);
		send_scan(10'h155, 32'd120);
		send_scan(10'h2AA, 32'd130);
		send_scan(10'h2AA, 32'd160);
		write_debounce(16'd0);
		send_scan(10'h0F0, 32'd200);
		send_scan(10'h0F0, 32'd200);
		send_scan(10'h00F, 32'd200);
		send_scan(10'h00F, 32'd200);
		write_debounce(16'hFFFF);
		send_scan(10'h3FF, 32'd1000);
		send_scan(10'h3FF, 32'd66534);
		send_scan(10'h3FF, 32'd66535);
		cur_raw  = 10'h3FF;
		cur_time = 32'd66535;

		write_debounce(DEBOUNCE_RESET);
		run_phase(90);
		write_debounce(16'd0);
		long_hold_req = 1'b1;
		run_phase(80);
		write_debounce(16'hFFFF);
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		run_phase(60);
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		write_debounce(16'd1);
		run_phase(80);
		deb_rand = $urandom_range(2, 200);
		write_debounce(DEB_W'(deb_rand));
		run_phase(80);
		drain_events(20);

		if (pending != 0) begin
			$error("%0d event words never arrived", pending);
		end
		$display("Run covered %0d scans and %0d event words with debounce times", scans_sent,
			events_checked);
		$display("20, 0, 65535, 1 and %0d ms, time wrap, backward time and a long output hold.",
			deb_rand);
		if (fail_count == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
